FILE: design/pba_pkg.sv
// Shared types and constants for the pixel brightness/afterglow filter.
// No dependencies; compiled first.
`default_nettype none

package pba_pkg;

    localparam int IDX_W      = 17;
    localparam int NUM_PIXELS = 1 << IDX_W;
    localparam int PIX_W      = 32;
    localparam int CH_W       = 8;
    localparam int SCALE_W    = 9;
    localparam int DECAY_W    = 8;
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;
    localparam int Q_DEPTH    = 4;
    localparam int QPTR_W     = 2;
    localparam int QCNT_W     = 3;

    typedef enum logic [1:0] {
        REG_FORMAT = 2'd0,
        REG_SCALE  = 2'd1,
        REG_DECAY  = 2'd2,
        REG_NONE   = 2'd3
    } reg_idx_t;

    typedef enum logic {
        FMT_RGB565   = 1'b0,
        FMT_ARGB8888 = 1'b1
    } pix_fmt_t;

    typedef logic [CH_W-1:0] chan_t;

endpackage

`default_nettype wire

FILE: design/pba_in_if.sv
// Input pixel channel: valid/ready plus pixel index and pixel word.
// Depends on pba_pkg.
`default_nettype none

interface pba_in_if;
    logic                     valid;
    logic                     ready;
    logic [pba_pkg::IDX_W-1:0] pixel_index;
    logic [pba_pkg::PIX_W-1:0] pixel_in;

    modport source (output valid, output pixel_index, output pixel_in, input ready);
    modport sink   (input valid, input pixel_index, input pixel_in, output ready);
endinterface

`default_nettype wire

FILE: design/pba_out_if.sv
// Output pixel channel: valid/ready plus filtered pixel word.
// Depends on pba_pkg.
`default_nettype none

interface pba_out_if;
    logic                     valid;
    logic                     ready;
    logic [pba_pkg::PIX_W-1:0] pixel_out;

    modport source (output valid, output pixel_out, input ready);
    modport sink   (input valid, input pixel_out, output ready);
endinterface

`default_nettype wire

FILE: design/pixel_brightness_afterglow.sv
// Pixel brightness scaling with afterglow blend against a per-pixel history RAM.
// Depends on pba_pkg, pba_in_if, pba_out_if.
// An accepted beat is registered in stage 1 and then in the output queue.
// Throughput: one beat per cycle while the queue has room and no clear is running;
// history RAM is read on accept and written in the following cycle, with a
// one-deep bypass for back-to-back hits on one index.
// Reset: config returns to ARGB8888, unity gain, afterglow off; the history RAM
// is then zeroed one entry a cycle (all 131072 entries) with input held off.
`default_nettype none

module pixel_brightness_afterglow (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    pba_in_if.sink                          video,
    pba_out_if.source                       filtered,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [pba_pkg::ADDR_W-1:0] paddr,
    input  wire logic [pba_pkg::DATA_W-1:0] pwdata,
    output logic      [pba_pkg::DATA_W-1:0] prdata,
    output logic                            pready
);
    import pba_pkg::*;

    // configuration
    pix_fmt_t             fmt_reg;
    logic [SCALE_W-1:0]   scale_reg;
    logic [DECAY_W-1:0]   decay_reg;
    reg_idx_t             reg_sel;
    logic                 cfg_wr;

    // clearing sweep
    logic                 clr_active_reg, clr_active_next;
    logic [IDX_W-1:0]     clr_addr_reg, clr_addr_next;

    // history RAM
    logic [PIX_W-1:0]     hist_mem [NUM_PIXELS];
    logic [PIX_W-1:0]     mem_rdata_reg;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic [PIX_W-1:0]     mem_wdata;

    // stage 1
    logic                 s1_valid_reg, s1_valid_next;
    logic [IDX_W-1:0]     s1_idx_reg;
    chan_t                s1_ch_reg [3];
    chan_t                s1_alpha_reg;
    logic                 fwd_hit_reg;
    logic [PIX_W-1:0]     fwd_data_reg;

    // output queue
    logic [PIX_W-1:0]     out_q [Q_DEPTH];
    logic [QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]    cnt_reg, cnt_next;

    logic                 accept;
    logic                 pop;
    logic                 glow;
    chan_t                in_ch [3];
    chan_t                sc_ch [3];
    logic [2*CH_W:0]      prod [3];
    logic [PIX_W-1:0]     hist_word;
    chan_t                h_ch [3];
    logic [2*CH_W-1:0]    mix [3];
    chan_t                res_ch [3];
    logic [PIX_W-1:0]     result;

    assign glow = (decay_reg != '0);

    // APB
    assign pready = 1'b1;
    assign reg_sel = reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_comb
    begin
        case (reg_sel)
            REG_FORMAT: prdata = DATA_W'(fmt_reg);
            REG_SCALE:  prdata = DATA_W'(scale_reg);
            REG_DECAY:  prdata = DATA_W'(decay_reg);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg   <= FMT_ARGB8888;
            scale_reg <= SCALE_W'(256);
            decay_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (reg_sel)
                REG_FORMAT: fmt_reg   <= pix_fmt_t'(pwdata[0]);
                REG_SCALE:  scale_reg <= pwdata[SCALE_W-1:0];
                REG_DECAY:  decay_reg <= pwdata[DECAY_W-1:0];
                default:    ;
            endcase
        end
    end

    // handshake
    assign accept = video.valid && video.ready;
    assign pop    = filtered.valid && filtered.ready;
    assign video.ready = !clr_active_reg && ((cnt_reg + QCNT_W'(s1_valid_reg)) <= QCNT_W'(2));

    // stage 0: unpack and scale
    always_comb
    begin
        if (fmt_reg == FMT_ARGB8888)
        begin
            in_ch[0] = video.pixel_in[23:16];
            in_ch[1] = video.pixel_in[15:8];
            in_ch[2] = video.pixel_in[7:0];
        end
        else
        begin
            in_ch[0] = CH_W'(video.pixel_in[15:11]);
            in_ch[1] = CH_W'(video.pixel_in[10:5]);
            in_ch[2] = CH_W'(video.pixel_in[4:0]);
        end
        for (int i = 0; i < 3; i++)
        begin
            prod[i]  = (2*CH_W+1)'(in_ch[i]) * (2*CH_W+1)'(scale_reg);
            sc_ch[i] = scale_reg[SCALE_W-1] ? in_ch[i] : prod[i][2*CH_W-1:CH_W];
        end
    end

    // stage 1: blend with history when decay is nonzero, then repack
    always_comb
    begin
        hist_word = fwd_hit_reg ? fwd_data_reg : mem_rdata_reg;
        if (fmt_reg == FMT_ARGB8888)
        begin
            h_ch[0] = hist_word[23:16];
            h_ch[1] = hist_word[15:8];
            h_ch[2] = hist_word[7:0];
        end
        else
        begin
            h_ch[0] = CH_W'(hist_word[15:11]);
            h_ch[1] = CH_W'(hist_word[10:5]);
            h_ch[2] = CH_W'(hist_word[4:0]);
        end
        for (int i = 0; i < 3; i++)
        begin
            mix[i] = (2*CH_W)'(s1_ch_reg[i]) * (2*CH_W)'(9'd256 - {1'b0, decay_reg})
                   + (2*CH_W)'(h_ch[i]) * (2*CH_W)'(decay_reg);
            res_ch[i] = glow ? mix[i][2*CH_W-1:CH_W] : s1_ch_reg[i];
        end
        if (fmt_reg == FMT_ARGB8888)
            result = {s1_alpha_reg, res_ch[0], res_ch[1], res_ch[2]};
        else
            result = {16'd0, res_ch[0][4:0], res_ch[1][5:0], res_ch[2][4:0]};
    end

    always_comb
    begin
        s1_valid_next = accept;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_idx_reg   <= video.pixel_index;
            s1_ch_reg    <= sc_ch;
            s1_alpha_reg <= (fmt_reg == FMT_ARGB8888) ? video.pixel_in[31:24] : '0;
            fwd_hit_reg  <= s1_valid_reg && glow && (s1_idx_reg == video.pixel_index);
            fwd_data_reg <= result;
        end
    end

    // clearing sweep
    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg)
        begin
            clr_addr_next = clr_addr_reg + IDX_W'(1);
            if (clr_addr_reg == '1)
                clr_active_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
        end
    end

    // history RAM
    always_comb
    begin
        if (clr_active_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = s1_valid_reg && glow;
            mem_waddr = s1_idx_reg;
            mem_wdata = result;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            hist_mem[mem_waddr] <= mem_wdata;
        if (accept)
            mem_rdata_reg <= hist_mem[video.pixel_index];
    end

    // output queue
    always_comb
    begin
        wr_ptr_next = s1_valid_reg ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + QCNT_W'(s1_valid_reg) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
            out_q[wr_ptr_reg] <= result;
    end

    assign filtered.valid     = (cnt_reg != '0);
    assign filtered.pixel_out = out_q[rd_ptr_reg];

endmodule

`default_nettype wire

FILE: bench/pixel_brightness_afterglow_tb.sv
// Self-checking bench for pixel_brightness_afterglow: directed probe table, then random
// phases with varied format, gain and decay, with random stalls on both channels.
// Depends on pba_pkg, pba_in_if, pba_out_if and the RTL; reads no files.

module pixel_brightness_afterglow_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import pba_pkg::*;

    localparam int PHASES      = 9;
    localparam int PHASE_BEATS = 50;
    localparam int STALL_LIMIT = 4 * NUM_PIXELS;

    typedef struct {
        pix_fmt_t           fmt;
        logic [SCALE_W-1:0] gain;
        logic [DECAY_W-1:0] decay;
        logic [IDX_W-1:0]   idx;
        logic [PIX_W-1:0]   px;
        bit                 known;
        logic [PIX_W-1:0]   want;
    } probe_t;

    typedef struct {
        bit               known;
        logic [PIX_W-1:0] want;
    } pin_t;

    localparam int PROBES = 23;

    probe_t probes [PROBES] = '{
        '{FMT_ARGB8888, 9'd256, 8'd0,   17'd0,      32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
        '{FMT_ARGB8888, 9'd256, 8'd0,   17'd131071, 32'h1234_5678, 1'b1, 32'h1234_5678},
        '{FMT_ARGB8888, 9'd256, 8'd0,   17'd1,      32'h0000_0000, 1'b1, 32'h0000_0000},
        '{FMT_ARGB8888, 9'd0,   8'd0,   17'd2,      32'hAABB_CCDD, 1'b1, 32'hAA00_0000},
        '{FMT_ARGB8888, 9'd511, 8'd0,   17'd3,      32'h80FF_0102, 1'b1, 32'h80FF_0102},
        '{FMT_ARGB8888, 9'd257, 8'd0,   17'd3,      32'h7F00_FF00, 1'b1, 32'h7F00_FF00},
        '{FMT_ARGB8888, 9'd128, 8'd0,   17'd4,      32'h00FF_8001, 1'b0, 32'h0},
        '{FMT_ARGB8888, 9'd255, 8'd0,   17'd4,      32'hFFFF_FFFF, 1'b0, 32'h0},
        '{FMT_RGB565,   9'd256, 8'd0,   17'd5,      32'hFFFF_1234, 1'b1, 32'h0000_1234},
        '{FMT_RGB565,   9'd0,   8'd0,   17'd5,      32'h0000_FFFF, 1'b1, 32'h0000_0000},
        '{FMT_RGB565,   9'd255, 8'd0,   17'd6,      32'h0000_FFFF, 1'b0, 32'h0},
        '{FMT_RGB565,   9'd128, 8'd0,   17'd6,      32'hA5A5_F81F, 1'b0, 32'h0},
        '{FMT_ARGB8888, 9'd256, 8'd255, 17'd7,      32'hFF80_8080, 1'b1, 32'hFF00_0000},
        '{FMT_ARGB8888, 9'd256, 8'd255, 17'd7,      32'h00FF_FFFF, 1'b0, 32'h0},
        '{FMT_ARGB8888, 9'd256, 8'd128, 17'd8,      32'h11FF_FFFF, 1'b0, 32'h0},
        '{FMT_ARGB8888, 9'd256, 8'd128, 17'd8,      32'h22FF_FFFF, 1'b0, 32'h0},
        '{FMT_ARGB8888, 9'd64,  8'd1,   17'd131071, 32'hFFFF_FFFF, 1'b0, 32'h0},
        '{FMT_RGB565,   9'd256, 8'd128, 17'd8,      32'h0000_FFFF, 1'b0, 32'h0},
        '{FMT_RGB565,   9'd200, 8'd200, 17'd8,      32'hABCD_FFFF, 1'b0, 32'h0},
        '{FMT_RGB565,   9'd256, 8'd0,   17'd9,      32'h0000_1234, 1'b1, 32'h0000_1234},
        '{FMT_RGB565,   9'd256, 8'd128, 17'd9,      32'h0000_FFFF, 1'b0, 32'h0},
        '{FMT_ARGB8888, 9'd0,   8'd255, 17'd8,      32'hFF12_3456, 1'b0, 32'h0},
        '{FMT_ARGB8888, 9'd256, 8'd1,   17'd131071, 32'h0000_0000, 1'b0, 32'h0}
    };

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    pba_in_if  video ();
    pba_out_if filtered ();

    pixel_brightness_afterglow u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .video    (video),
        .filtered (filtered),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    pix_fmt_t           cfg_fmt   = FMT_ARGB8888;
    logic [SCALE_W-1:0] cfg_gain  = 9'd256;
    logic [DECAY_W-1:0] cfg_decay = 8'd0;
    logic [PIX_W-1:0]   glow_mem [logic [IDX_W-1:0]];

    logic [PIX_W-1:0]   expected_pixels [$];
    pin_t               pinned [$];
    bit                 faulty;
    bit                 quiet;
    int                 stall_cycles = 0;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [PIX_W-1:0] filter_pixel(input logic [IDX_W-1:0] idx,
                                                       input logic [PIX_W-1:0] px);
        logic [CH_W-1:0]  c [3];
        logic [CH_W-1:0]  h [3];
        logic [PIX_W-1:0] hist;
        logic [16:0]      acc;
        logic [PIX_W-1:0] result;
        hist = glow_mem.exists(idx) ? glow_mem[idx] : '0;
        if (cfg_fmt == FMT_ARGB8888)
        begin
            c[0] = px[23:16];
            c[1] = px[15:8];
            c[2] = px[7:0];
            h[0] = hist[23:16];
            h[1] = hist[15:8];
            h[2] = hist[7:0];
        end
        else
        begin
            c[0] = {3'b0, px[15:11]};
            c[1] = {2'b0, px[10:5]};
            c[2] = {3'b0, px[4:0]};
            h[0] = {3'b0, hist[15:11]};
            h[1] = {2'b0, hist[10:5]};
            h[2] = {3'b0, hist[4:0]};
        end
        for (int i = 0; i < 3; i++)
        begin
            if (cfg_gain < 9'd256)
            begin
                acc  = c[i] * cfg_gain;
                c[i] = acc[15:8];
            end
            if (cfg_decay != 8'd0)
            begin
                acc  = c[i] * (9'd256 - cfg_decay) + h[i] * cfg_decay;
                c[i] = acc[15:8];
            end
        end
        if (cfg_fmt == FMT_ARGB8888)
            result = {px[31:24], c[0], c[1], c[2]};
        else
            result = {16'b0, c[0][4:0], c[1][5:0], c[2][4:0]};
        if (cfg_decay != 8'd0)
            glow_mem[idx] = result;
        return result;
    endfunction

    always @(posedge clk)
    begin : scoreboard
        logic [PIX_W-1:0] model_px;
        logic [PIX_W-1:0] want;
        pin_t             pin;
        bit               moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (video.valid && video.ready)
            begin
                moved = 1'b1;
                model_px = filter_pixel(video.pixel_index, video.pixel_in);
                pin = pinned.pop_front();
                expected_pixels.push_back(pin.known ? pin.want : model_px);
            end
            if (filtered.valid && filtered.ready)
            begin
                moved = 1'b1;
                if (expected_pixels.size() == 0)
                begin
                    faulty = 1'b1;
                    $display("%0t: pixel_out expected none, got %08h", $time,
                             filtered.pixel_out);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (filtered.pixel_out !== want)
                    begin
                        faulty = 1'b1;
                        $display("%0t: pixel_out expected %08h, got %08h", $time, want,
                                 filtered.pixel_out);
                    end
                end
            end
            stall_cycles <= moved ? 0 : stall_cycles + 1;
        end
    end

    initial
    begin
        filtered.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!quiet && $urandom_range(0, 6) == 0)
            begin
                filtered.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            filtered.ready <= 1'b1;
        end
    end

    initial
    begin
        @(posedge rst_n);
        while (stall_cycles < STALL_LIMIT) @(posedge clk);
        $display("pixel_brightness_afterglow: mismatch");
        $finish;
    end

    task automatic write_reg(input reg_idx_t r, input logic [DATA_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (r)
            REG_FORMAT: cfg_fmt   = pix_fmt_t'(v[0]);
            REG_SCALE:  cfg_gain  = v[SCALE_W-1:0];
            REG_DECAY:  cfg_decay = v[DECAY_W-1:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        video.valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (expected_pixels.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic retune(input pix_fmt_t fmt, input logic [SCALE_W-1:0] gain,
                          input logic [DECAY_W-1:0] decay, input bit every);
        if (!every && fmt == cfg_fmt && gain == cfg_gain && decay == cfg_decay)
            return;
        drain();
        if (every || fmt != cfg_fmt)
            write_reg(REG_FORMAT, DATA_W'(fmt));
        if (every || gain != cfg_gain)
            write_reg(REG_SCALE, DATA_W'(gain));
        if (every || decay != cfg_decay)
            write_reg(REG_DECAY, DATA_W'(decay));
    endtask

    task automatic send_pixel(input logic [IDX_W-1:0] idx, input logic [PIX_W-1:0] px,
                              input bit known, input logic [PIX_W-1:0] want);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            video.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        pinned.push_back(pin_t'{known, want});
        video.valid       <= 1'b1;
        video.pixel_index <= idx;
        video.pixel_in    <= px;
        do @(posedge clk); while (!video.ready);
    endtask

    function automatic logic [SCALE_W-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0: return 9'd0;
            1: return 9'd255;
            2: return 9'd256;
            3: return 9'd511;
            default: return SCALE_W'($urandom_range(0, 511));
        endcase
    endfunction

    function automatic logic [DECAY_W-1:0] pick_decay();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'd1;
            2: return 8'd255;
            default: return DECAY_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [IDX_W-1:0] pick_index();
        case ($urandom_range(0, 9))
            0: return IDX_W'($urandom_range(0, NUM_PIXELS - 1));
            1: return IDX_W'(NUM_PIXELS - 1 - $urandom_range(0, 3));
            default: return IDX_W'($urandom_range(0, 7));
        endcase
    endfunction

    initial
    begin
        pix_fmt_t           fmt;
        logic [SCALE_W-1:0] gain;
        logic [DECAY_W-1:0] decay;
        faulty            = 1'b0;
        quiet             = 1'b0;
        rst_n             <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        video.valid       <= 1'b0;
        video.pixel_index <= '0;
        video.pixel_in    <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (probes[i])
        begin
            retune(probes[i].fmt, probes[i].gain, probes[i].decay, 1'b0);
            send_pixel(probes[i].idx, probes[i].px, probes[i].known, probes[i].want);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: begin fmt = FMT_ARGB8888; gain = 9'd511; decay = 8'd255; end
                1: begin fmt = FMT_RGB565;   gain = 9'd0;   decay = 8'd1;   end
                2: begin fmt = FMT_RGB565;   gain = 9'd256; decay = 8'd255; end
                3: begin fmt = FMT_ARGB8888; gain = 9'd255; decay = 8'd0;   end
                default:
                begin
                    fmt   = pix_fmt_t'($urandom_range(0, 1));
                    gain  = pick_gain();
                    decay = pick_decay();
                end
            endcase
            retune(fmt, gain, decay, p == 0);
            quiet = (p == PHASES - 1) || ($urandom_range(0, 4) == 0);
            for (int n = 0; n < PHASE_BEATS; n++)
                send_pixel(pick_index(), $urandom, 1'b0, '0);
        end

        drain();
        if (!faulty)
            $display("pixel_brightness_afterglow: match");
        else
            $display("pixel_brightness_afterglow: mismatch");
        $finish;
    end

endmodule

FILE: sim.f
design/pba_pkg.sv
design/pba_in_if.sv
design/pba_out_if.sv
design/pixel_brightness_afterglow.sv
bench/pixel_brightness_afterglow_tb.sv
